// ===== rtl/mti_pkg.sv =====
// Package for the multichannel trapezoid integrator.
// Holds command codes, config register indices and the step divisor. No dependencies.
package mti_pkg;
  localparam logic [1:0] CMD_RESET  = 2'd0;
  localparam logic [1:0] CMD_SCAN   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_MULT   = 1'b1;

  localparam int unsigned StepDivisor = 100;
endpackage

// ===== rtl/mti_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Unsigned 64/64 division; sign handling is left to the caller. Uses mti_pkg.
module mti_divider import mti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);
  logic [63:0] quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] trial;

  // one shift-subtract step
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[63]} - {1'b0, dsr_q};
    done_o = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quotient_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end
endmodule

// ===== rtl/multichannel_trapezoid_integrator.sv =====
// Multichannel trapezoid integrator, top level. Uses mti_pkg, mti_divider.
// Steps per command: reset and first scan read, then finish; scan adds four
// 16-bit reciprocal steps for /100; sample does read, multiply, write; read
// does read and multiply; scaled read adds the 64-step shared divider. Input
// stalls until the core is idle again; a stalled result holds the core.
// Reset: asynchronous, active low; per-channel valid bits give zero contents.
module multichannel_trapezoid_integrator import mti_pkg::*; #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  channel_i,
  input  logic signed [15:0] sample_i,
  input  logic [63:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] value_o,
  output logic signed [31:0] pos_sum_o,
  output logic signed [31:0] neg_sum_o,
  output logic [30:0] peak_area_o,
  output logic signed [31:0] scans_seen_o,
  output logic        divide_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // ceil(2^30 / 100): exact quotient for numerators below 100 * 2^16
  localparam logic [23:0] StepRecip = 24'd10737419;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_SDIV = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_q;
  logic [1:0] cmd_q;
  logic [3:0] ch_q;
  logic       ok_q;
  logic [CW-1:0] idx;
  logic signed [15:0] smp_q;
  logic [63:0] ts_q;

  // channel memory, invalid entries read as zero
  logic [15:0] mem_smp [CHANNELS];
  logic [31:0] mem_pos [CHANNELS];
  logic [31:0] mem_neg [CHANNELS];
  logic [30:0] mem_pk  [CHANNELS];
  logic [CHANNELS-1:0] sv_q;   // sample valid
  logic [CHANNELS-1:0] av_q;   // sums valid
  logic [15:0] rd_smp_q;
  logic [31:0] rd_pos_q, rd_neg_q;
  logic [30:0] rd_pk_q;

  logic [63:0] last_time_q;
  logic [31:0] step_q, elapsed_q, scan_q;
  logic        scale_en_q;
  logic [31:0] mult_q;

  logic [31:0] prod_a_q;  // prev*dT
  logic [31:0] area_q;
  logic        neg_q;     // sign of scaled quotient
  logic [31:0] res_val_q;
  logic        res_err_q;

  logic        div_start, div_done;
  logic [63:0] div_dnd, div_dsr, div_quo;

  logic        out_valid_q;
  logic [31:0] o_val_q, o_pos_q, o_neg_q, o_scan_q;
  logic [30:0] o_pk_q;
  logic        o_err_q;

  logic accept;
  logic done_fire;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign done_fire   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign idx         = CW'(ch_q);

  // datapath terms
  logic [63:0] tdiff;
  logic [31:0] diffv, area_c, mag_c, elap_abs;
  logic signed [63:0] prod_s;
  assign tdiff  = ts_q - last_time_q;
  assign diffv  = rd_pos_q - rd_neg_q;
  assign prod_s = $signed(diffv) * $signed(mult_q);
  assign elap_abs = elapsed_q[31] ? (32'd0 - elapsed_q) : elapsed_q;
  assign area_c = prod_a_q
                + {area_q[31], area_q[31:1]};
  assign mag_c  = (area_c == 32'h8000_0000) ? 32'h7FFF_FFFF :
                  area_c[31] ? (32'd0 - area_c) : area_c;

  // step width: tick difference / 100, 16 bits per cycle by reciprocal
  logic [63:0] sd_num_q;
  logic [6:0]  sd_rem_q;
  logic [15:0] sd_quo_q;
  logic [1:0]  sd_cnt_q;
  logic [22:0] sd_n, sd_qx, sd_rn;
  logic [46:0] sd_prod;
  logic [15:0] sd_q;
  logic [31:0] sd_step;
  assign sd_n    = {sd_rem_q, sd_num_q[63:48]};
  assign sd_prod = {24'd0, sd_n} * {23'd0, StepRecip};
  assign sd_q    = sd_prod[45:30];
  assign sd_qx   = {7'd0, sd_q} * 23'(StepDivisor);
  assign sd_rn   = sd_n - sd_qx;
  assign sd_step = {sd_quo_q, sd_q};

  mti_divider u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_dnd),
    .divisor_i (div_dsr),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // scaled read: magnitudes into the divider, sign applied afterwards
  assign div_start = (state_q == ST_MUL1) && (cmd_q == CMD_READ) && ok_q && scale_en_q
                     && (elapsed_q != 32'd0);
  assign div_dnd   = prod_s[63] ? (64'd0 - $unsigned(prod_s)) : $unsigned(prod_s);
  assign div_dsr   = {32'd0, elap_abs};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sv_q        <= '0;
      av_q        <= '0;
      scan_q      <= 32'hFFFF_FFFF;
      elapsed_q   <= '0;
      step_q      <= '0;
      last_time_q <= '0;
      scale_en_q  <= 1'b0;
      mult_q      <= 32'd1;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_ENABLE) scale_en_q <= cfg_data_i[0];
        else                           mult_q     <= cfg_data_i;
      end
      if (done_fire)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (accept) state_q <= ST_READ;
        ST_READ: begin
          case (cmd_q)
            CMD_RESET: begin
              elapsed_q <= '0;
              scan_q    <= '0;
              av_q      <= '0;
              state_q   <= ST_DONE;
            end
            CMD_SCAN: begin
              scan_q      <= scan_q + 32'd1;
              last_time_q <= ts_q;
              state_q     <= (scan_q == 32'hFFFF_FFFF) ? ST_DONE : ST_SDIV;
            end
            default: state_q <= ST_MUL1;
          endcase
        end
        ST_SDIV: begin
          if (sd_cnt_q == 2'd3) begin
            step_q    <= sd_step;
            elapsed_q <= elapsed_q + sd_step;
            state_q   <= ST_DONE;
          end
        end
        ST_MUL1: begin
          if (cmd_q == CMD_READ) state_q <= div_start ? ST_DIV : ST_DONE;
          else                   state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          if (ok_q) begin
            sv_q[idx] <= 1'b1;
            if (scan_q != 32'd0 && scan_q != 32'hFFFF_FFFF) av_q[idx] <= 1'b1;
          end
          state_q <= ST_DONE;
        end
        ST_DIV: if (div_done) state_q <= ST_DONE;
        ST_DONE: if (done_fire) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload: item capture, memory port, arithmetic
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      ch_q  <= channel_i;
      ok_q  <= 32'(channel_i) < CHANNELS;
      smp_q <= sample_i;
      ts_q  <= timestamp_i;
    end
    if (state_q == ST_READ) begin
      rd_smp_q  <= sv_q[idx] ? mem_smp[idx] : 16'd0;
      rd_pos_q  <= av_q[idx] ? mem_pos[idx] : 32'd0;
      rd_neg_q  <= av_q[idx] ? mem_neg[idx] : 32'd0;
      rd_pk_q   <= av_q[idx] ? mem_pk[idx]  : 31'd0;
      res_val_q <= '0;
      res_err_q <= 1'b0;
      sd_num_q  <= tdiff;
      sd_rem_q  <= '0;
      sd_cnt_q  <= '0;
    end
    if (state_q == ST_SDIV) begin
      sd_num_q <= {sd_num_q[47:0], 16'd0};
      sd_rem_q <= sd_rn[6:0];
      sd_quo_q <= sd_q;
      sd_cnt_q <= sd_cnt_q + 2'd1;
    end
    if (state_q == ST_MUL1) begin
      prod_a_q <= {{16{rd_smp_q[15]}}, rd_smp_q} * step_q;
      area_q   <= ({{16{smp_q[15]}}, smp_q} - {{16{rd_smp_q[15]}}, rd_smp_q}) * step_q;
      neg_q    <= diffv[31] ^ mult_q[31] ^ elapsed_q[31];
      if (cmd_q == CMD_READ) begin
        res_val_q <= (ok_q && !scale_en_q) ? diffv : 32'd0;
        res_err_q <= ok_q && scale_en_q && (elapsed_q == 32'd0);
      end
    end
    if (state_q == ST_DIV && div_done)
      res_val_q <= neg_q ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
    if (state_q == ST_MUL2 && ok_q) begin
      mem_smp[idx] <= smp_q;
      if (scan_q != 32'd0 && scan_q != 32'hFFFF_FFFF) begin
        mem_pos[idx] <= rd_pos_q + (!area_c[31] && area_c != 0 ? area_c : 32'd0);
        mem_neg[idx] <= rd_neg_q + (!area_c[31] && area_c != 0 ? 32'd0 : area_c);
        mem_pk[idx]  <= (mag_c[30:0] > rd_pk_q) ? mag_c[30:0] : rd_pk_q;
        rd_pos_q <= rd_pos_q + (!area_c[31] && area_c != 0 ? area_c : 32'd0);
        rd_neg_q <= rd_neg_q + (!area_c[31] && area_c != 0 ? 32'd0 : area_c);
        rd_pk_q  <= (mag_c[30:0] > rd_pk_q) ? mag_c[30:0] : rd_pk_q;
      end
    end
    if (done_fire) begin
      o_val_q  <= res_val_q;
      o_err_q  <= res_err_q;
      o_pos_q  <= (ok_q && cmd_q != CMD_RESET) ? rd_pos_q : 32'd0;
      o_neg_q  <= (ok_q && cmd_q != CMD_RESET) ? rd_neg_q : 32'd0;
      o_pk_q   <= (ok_q && cmd_q != CMD_RESET) ? rd_pk_q  : 31'd0;
      o_scan_q <= scan_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = o_val_q;
  assign pos_sum_o      = o_pos_q;
  assign neg_sum_o      = o_neg_q;
  assign peak_area_o    = o_pk_q;
  assign scans_seen_o   = o_scan_q;
  assign divide_error_o = o_err_q;

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o) else $error("item taken while busy");
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> out_valid_o) else $error("result lost");
  a_err_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_error_o |-> value_o == 32'd0) else $error("bad error value");
endmodule
